### hdl/csp_pkg.sv
`default_nettype none
package csp_pkg;

   localparam int MAX_STORES_DEF = 64;
   localparam int SIZE_WIDTH_DEF = 48;
   localparam int CFG_SIZE_W = 48;
   localparam int CSR_IDX_W = 3;
   localparam int SUM_W = 64;
   localparam int RATIO_W = 16;
   localparam int PROD_W = SUM_W + RATIO_W;
   localparam int PICK_W = 7;
   localparam int OVL_W = 10;
   localparam int TAG_W = 16;
   localparam int PICK_CAP = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MIN_PICK    = 3'd0,
      REG_MAX_PICK    = 3'd1,
      REG_SIZE_BASE   = 3'd2,
      REG_SIZE_RATIO  = 3'd3,
      REG_EDEN_CUTOFF = 3'd4,
      REG_OVL_LIMIT   = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic [PICK_W-1:0]     min_pick;
      logic [PICK_W-1:0]     max_pick;
      logic [CFG_SIZE_W-1:0] size_base;
      logic [RATIO_W-1:0]    size_ratio;
      logic [CFG_SIZE_W-1:0] eden_cutoff;
      logic [OVL_W-1:0]      overlap_limit;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      min_pick:      7'd3,
      max_pick:      7'd5,
      size_base:     48'd16777216,
      size_ratio:    16'd512,
      eden_cutoff:   48'd100663296,
      overlap_limit: 10'd30
   };

endpackage
`default_nettype wire

### hdl/csp_regs.sv
`default_nettype none
module csp_regs (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   input  wire logic [csp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [csp_pkg::CFG_SIZE_W-1:0]   csr_data,
   output csp_pkg::cfg_type                      cfg_o
);

   csp_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= csp_pkg::CFG_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            csp_pkg::REG_MIN_PICK:    cfg_ff.min_pick <= csr_data[csp_pkg::PICK_W-1:0];
            csp_pkg::REG_MAX_PICK:    cfg_ff.max_pick <= csr_data[csp_pkg::PICK_W-1:0];
            csp_pkg::REG_SIZE_BASE:   cfg_ff.size_base <= csr_data;
            csp_pkg::REG_SIZE_RATIO:  cfg_ff.size_ratio <= csr_data[csp_pkg::RATIO_W-1:0];
            csp_pkg::REG_EDEN_CUTOFF: cfg_ff.eden_cutoff <= csr_data;
            csp_pkg::REG_OVL_LIMIT:   cfg_ff.overlap_limit <= csr_data[csp_pkg::OVL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg_o = cfg_ff;

endmodule
`default_nettype wire

### hdl/csp_ratio.sv
`default_nettype none
module csp_ratio #(
   parameter int SIZE_WIDTH = csp_pkg::SIZE_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic [SIZE_WIDTH-1:0]         size_i,
   input  wire logic [csp_pkg::SUM_W-1:0]     sum_i,
   input  wire logic [csp_pkg::RATIO_W-1:0]   ratio_i,
   output logic                               exceeds_o
);

   logic [csp_pkg::PROD_W-1:0] prod_in;
   logic [csp_pkg::PROD_W-1:0] prod_ff;
   logic [SIZE_WIDTH-1:0]      size_ff;

   assign prod_in = csp_pkg::PROD_W'(sum_i) * csp_pkg::PROD_W'(ratio_i);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      size_ff <= size_i;
   end

   // size * 256 > sum * ratio
   assign exceeds_o = (csp_pkg::PROD_W'(size_ff) << 8) > prod_ff;

endmodule
`default_nettype wire

### hdl/csp_seq.sv
`default_nettype none
module csp_seq #(
   parameter int MAX_STORES = csp_pkg::MAX_STORES_DEF,
   parameter int SIZE_WIDTH = csp_pkg::SIZE_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire csp_pkg::cfg_type              cfg_i,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [csp_pkg::TAG_W-1:0]     req_store_tag,
   input  wire logic [SIZE_WIDTH-1:0]         req_store_size,
   input  wire logic                          req_compactable,
   input  wire logic                          req_reason_flag,
   input  wire logic                          req_in_eden,
   input  wire logic [csp_pkg::OVL_W-1:0]     req_overlap_count,
   input  wire logic                          req_last_store,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [csp_pkg::TAG_W-1:0]          rsp_picked_tag,
   output logic                               rsp_none_picked,
   output logic                               rsp_last_pick
);

   localparam int CW = $clog2(MAX_STORES + 1);
   localparam int IW = $clog2(MAX_STORES);
   localparam int LW = (CW > csp_pkg::PICK_W) ? CW : csp_pkg::PICK_W;
   localparam int CAP = (csp_pkg::PICK_CAP < MAX_STORES) ? csp_pkg::PICK_CAP : MAX_STORES;
   localparam int TW = csp_pkg::TAG_W;

   typedef enum logic [3:0] {
      S_IDLE, S_FL_RD, S_FL_OUT, S_RK_LD, S_RK_LATCH, S_RK_SCAN,
      S_W_START, S_W_CHK, S_W_RD, S_W_MUL, S_W_CMP, S_W_END,
      S_E_RD, S_E_OUT, S_N_OUT
   } state_type;

   // memories
   logic [SIZE_WIDTH-1:0] cand_size_mem [MAX_STORES];
   logic [TW-1:0]         cand_tag_mem  [MAX_STORES];
   logic [TW-1:0]         flag_tag_mem  [MAX_STORES];
   logic [SIZE_WIDTH-1:0] srt_size_mem  [MAX_STORES];
   logic [TW-1:0]         srt_tag_mem   [MAX_STORES];

   logic [SIZE_WIDTH-1:0] cand_size_q, srt_size_q;
   logic [TW-1:0]         cand_tag_q, flag_tag_q, srt_tag_q;
   logic [IW-1:0]         cand_raddr, srt_raddr, flag_raddr;
   logic                  cand_we, flag_we, srt_we;

   state_type             state_ff, state_in;
   logic [CW-1:0]         cand_cnt_ff, cand_cnt_in, flag_cnt_ff, flag_cnt_in;
   logic                  eden_ff, eden_in, first_ff, first_in;
   logic [csp_pkg::OVL_W-1:0] ovl_ff, ovl_in;
   logic [CW-1:0]         i_ff, i_in, j_ff, j_in, len_ff, len_in;
   logic [CW-1:0]         pidx_ff, pidx_in, rank_ff, rank_in, k_ff, k_in, kend_ff, kend_in;
   logic                  pend_ff, pend_in;
   logic [SIZE_WIDTH-1:0] si_ff, si_in;
   logic [TW-1:0]         ti_ff, ti_in;
   logic [csp_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0]         rsp_tag_ff, rsp_tag_in;
   logic                  rsp_none_ff, rsp_none_in, rsp_last_ff, rsp_last_in;

   logic [LW-1:0]         maxl, minl;
   logic                  accept, eden_eff, eligible, flag_ok, out_free, critical;
   logic                  less, stop, exceeds;
   logic [csp_pkg::SUM_W:0] sum_add;
   logic [CW-1:0]         nc, nf;

   always_ff @(posedge clock) begin
      if (cand_we) begin
         cand_size_mem[cand_cnt_ff[IW-1:0]] <= req_store_size;
         cand_tag_mem[cand_cnt_ff[IW-1:0]] <= req_store_tag;
      end
      if (flag_we) begin
         flag_tag_mem[flag_cnt_ff[IW-1:0]] <= req_store_tag;
      end
      if (srt_we) begin
         srt_size_mem[rank_ff[IW-1:0]] <= si_ff;
         srt_tag_mem[rank_ff[IW-1:0]] <= ti_ff;
      end
      cand_size_q <= cand_size_mem[cand_raddr];
      cand_tag_q <= cand_tag_mem[cand_raddr];
      flag_tag_q <= flag_tag_mem[flag_raddr];
      srt_size_q <= srt_size_mem[srt_raddr];
      srt_tag_q <= srt_tag_mem[srt_raddr];
   end

   csp_ratio #(.SIZE_WIDTH(SIZE_WIDTH)) u_ratio (
      .clock     (clock),
      .size_i    (srt_size_q),
      .sum_i     (sum_ff),
      .ratio_i   (cfg_i.size_ratio),
      .exceeds_o (exceeds)
   );

   always_comb begin
      maxl = LW'(cfg_i.max_pick);
      if (maxl == '0) maxl = LW'(1);
      if (maxl > LW'(CAP)) maxl = LW'(CAP);
      minl = LW'(cfg_i.min_pick);
      if (minl == '0) minl = LW'(1);
   end

   assign req_ready = (state_ff == S_IDLE);
   assign accept = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign eden_eff = first_ff ? eden_ff : req_in_eden;
   assign eligible = req_compactable && cand_cnt_ff < CW'(MAX_STORES) &&
                     !(eden_eff && 64'(req_store_size) >= 64'(cfg_i.eden_cutoff));
   assign flag_ok = eligible && req_reason_flag && LW'(flag_cnt_ff) < maxl;
   assign cand_we = accept && eligible;
   assign flag_we = accept && flag_ok;
   assign nc = cand_cnt_ff + CW'(eligible);
   assign nf = flag_cnt_ff + CW'(flag_ok);
   assign critical = ovl_ff >= cfg_i.overlap_limit;
   assign less = (cand_size_q < si_ff) || (cand_size_q == si_ff && pidx_ff < i_ff);
   assign stop = !critical && 64'(srt_size_q) > 64'(cfg_i.size_base) &&
                 sum_ff != '0 && exceeds;
   assign sum_add = {1'b0, sum_ff} + (csp_pkg::SUM_W + 1)'(srt_size_q);
   assign srt_we = (state_ff == S_RK_SCAN) && !pend_ff && j_ff == cand_cnt_ff;

   always_comb begin
      case (state_ff)
         S_RK_SCAN: cand_raddr = j_ff[IW-1:0];
         default:   cand_raddr = i_ff[IW-1:0];
      endcase
      case (state_ff)
         S_E_RD, S_E_OUT: srt_raddr = k_ff[IW-1:0];
         default:         srt_raddr = j_ff[IW-1:0];
      endcase
      flag_raddr = k_ff[IW-1:0];
   end

   always_comb begin
      state_in = state_ff;
      cand_cnt_in = cand_cnt_ff;
      flag_cnt_in = flag_cnt_ff;
      eden_in = eden_ff;
      ovl_in = ovl_ff;
      first_in = first_ff;
      i_in = i_ff;
      j_in = j_ff;
      len_in = len_ff;
      pidx_in = pidx_ff;
      rank_in = rank_ff;
      k_in = k_ff;
      kend_in = kend_ff;
      pend_in = pend_ff;
      si_in = si_ff;
      ti_in = ti_ff;
      sum_in = sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_tag_in = rsp_tag_ff;
      rsp_none_in = rsp_none_ff;
      rsp_last_in = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (!first_ff) begin
                  eden_in = req_in_eden;
                  ovl_in = req_overlap_count;
                  first_in = 1'b1;
               end
               cand_cnt_in = nc;
               flag_cnt_in = nf;
               if (req_last_store) begin
                  k_in = '0;
                  i_in = '0;
                  if (nf != '0) state_in = S_FL_RD;
                  else if (nc != '0) state_in = S_RK_LD;
                  else state_in = S_N_OUT;
               end
            end
         end
         S_FL_RD: state_in = S_FL_OUT;
         S_FL_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_tag_in = flag_tag_q;
               rsp_none_in = 1'b0;
               rsp_last_in = (k_ff + CW'(1) == flag_cnt_ff);
               k_in = k_ff + CW'(1);
               state_in = S_FL_RD;
               if (k_ff + CW'(1) == flag_cnt_ff) begin
                  state_in = S_IDLE;
                  cand_cnt_in = '0;
                  flag_cnt_in = '0;
                  eden_in = 1'b0;
                  ovl_in = '0;
                  first_in = 1'b0;
               end
            end
         end
         S_RK_LD: state_in = S_RK_LATCH;
         S_RK_LATCH: begin
            si_in = cand_size_q;
            ti_in = cand_tag_q;
            j_in = '0;
            pend_in = 1'b0;
            rank_in = '0;
            state_in = S_RK_SCAN;
         end
         S_RK_SCAN: begin
            if (pend_ff && less) rank_in = rank_ff + CW'(1);
            if (j_ff < cand_cnt_ff) begin
               pend_in = 1'b1;
               pidx_in = j_ff;
               j_in = j_ff + CW'(1);
            end else begin
               pend_in = 1'b0;
            end
            if (!pend_ff && j_ff == cand_cnt_ff) begin
               if (i_ff + CW'(1) == cand_cnt_ff) begin
                  i_in = '0;
                  state_in = S_W_START;
               end else begin
                  i_in = i_ff + CW'(1);
                  state_in = S_RK_LD;
               end
            end
         end
         S_W_START: begin
            if (i_ff >= cand_cnt_ff) begin
               state_in = S_N_OUT;
            end else begin
               j_in = i_ff;
               len_in = '0;
               sum_in = '0;
               state_in = S_W_CHK;
            end
         end
         S_W_CHK: begin
            if (j_ff < cand_cnt_ff && LW'(len_ff) < maxl) state_in = S_W_RD;
            else state_in = S_W_END;
         end
         S_W_RD: state_in = S_W_MUL;
         S_W_MUL: state_in = S_W_CMP;
         S_W_CMP: begin
            if (stop) begin
               state_in = S_W_END;
            end else begin
               sum_in = sum_add[csp_pkg::SUM_W] ? '1 : sum_add[csp_pkg::SUM_W-1:0];
               j_in = j_ff + CW'(1);
               len_in = len_ff + CW'(1);
               state_in = S_W_CHK;
            end
         end
         S_W_END: begin
            if (LW'(len_ff) >= minl) begin
               k_in = i_ff;
               kend_in = j_ff;
               state_in = S_E_RD;
            end else begin
               i_in = i_ff + CW'(1);
               state_in = S_W_START;
            end
         end
         S_E_RD: state_in = S_E_OUT;
         S_E_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_tag_in = srt_tag_q;
               rsp_none_in = 1'b0;
               rsp_last_in = (k_ff + CW'(1) == kend_ff);
               k_in = k_ff + CW'(1);
               state_in = S_E_RD;
               if (k_ff + CW'(1) == kend_ff) begin
                  state_in = S_IDLE;
                  cand_cnt_in = '0;
                  flag_cnt_in = '0;
                  eden_in = 1'b0;
                  ovl_in = '0;
                  first_in = 1'b0;
               end
            end
         end
         S_N_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_tag_in = '0;
               rsp_none_in = 1'b1;
               rsp_last_in = 1'b1;
               state_in = S_IDLE;
               cand_cnt_in = '0;
               flag_cnt_in = '0;
               eden_in = 1'b0;
               ovl_in = '0;
               first_in = 1'b0;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      len_ff <= len_in;
      pidx_ff <= pidx_in;
      rank_ff <= rank_in;
      k_ff <= k_in;
      kend_ff <= kend_in;
      pend_ff <= pend_in;
      si_ff <= si_in;
      ti_ff <= ti_in;
      sum_ff <= sum_in;
      rsp_tag_ff <= rsp_tag_in;
      rsp_none_ff <= rsp_none_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff <= S_IDLE;
         cand_cnt_ff <= '0;
         flag_cnt_ff <= '0;
         eden_ff <= 1'b0;
         ovl_ff <= '0;
         first_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cand_cnt_ff <= cand_cnt_in;
         flag_cnt_ff <= flag_cnt_in;
         eden_ff <= eden_in;
         ovl_ff <= ovl_in;
         first_ff <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_picked_tag = rsp_tag_ff;
   assign rsp_none_picked = rsp_none_ff;
   assign rsp_last_pick = rsp_last_ff;

endmodule
`default_nettype wire

### hdl/compaction_store_picker_unit.sv
// Compaction store picker: takes one partition's stores as requests and
// returns the tags of the stores chosen for compaction.
// Request channel (req_*): one store per request, one request per cycle
// while loading. The request with req_last_store set starts selection and
// req_stall stays high until the partition's last result sits in the
// output register.
// Response channel (rsp_*): one result per pick, rsp_last_pick on the final
// one; a single result with rsp_none_picked when nothing is chosen.
// After the last store: flagged picks are read and emitted one by one;
// otherwise ranking runs on one comparator over the candidate memory's
// single read port, then the window scan steps through the ratio
// multiplier, and emission reads and emits one result at a time.
// A stalled response holds in the output register; the next result waits on it.
// Configuration (csr_*) is always ready; the user writes it only while idle (not enforced).
// Reset (synchronous) restores register defaults and empties the partition;
// no clearing pass is needed.
`default_nettype none
module compaction_store_picker_unit #(
   parameter int MAX_STORES = csp_pkg::MAX_STORES_DEF,
   parameter int SIZE_WIDTH = csp_pkg::SIZE_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [csp_pkg::TAG_W-1:0]       req_store_tag,
   input  wire logic [SIZE_WIDTH-1:0]           req_store_size,
   input  wire logic                            req_compactable,
   input  wire logic                            req_reason_flag,
   input  wire logic                            req_in_eden,
   input  wire logic [csp_pkg::OVL_W-1:0]       req_overlap_count,
   input  wire logic                            req_last_store,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [csp_pkg::TAG_W-1:0]            rsp_picked_tag,
   output logic                                 rsp_none_picked,
   output logic                                 rsp_last_pick,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [csp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [csp_pkg::CFG_SIZE_W-1:0]  csr_data
);

   csp_pkg::cfg_type cfg;
   logic             ready;

   assign csr_ready = 1'b1;
   assign req_stall = !ready;

   csp_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg_o     (cfg)
   );

   csp_seq #(.MAX_STORES(MAX_STORES), .SIZE_WIDTH(SIZE_WIDTH)) u_seq (
      .clock             (clock),
      .reset             (reset),
      .cfg_i             (cfg),
      .req_valid         (req_valid),
      .req_ready         (ready),
      .req_store_tag     (req_store_tag),
      .req_store_size    (req_store_size),
      .req_compactable   (req_compactable),
      .req_reason_flag   (req_reason_flag),
      .req_in_eden       (req_in_eden),
      .req_overlap_count (req_overlap_count),
      .req_last_store    (req_last_store),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_picked_tag    (rsp_picked_tag),
      .rsp_none_picked   (rsp_none_picked),
      .rsp_last_pick     (rsp_last_pick)
   );

endmodule
`default_nettype wire

### hdl/csp_checker.sv
`default_nettype none
module csp_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic req_last_store,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic [15:0] rsp_picked_tag,
   input wire logic rsp_none_picked,
   input wire logic rsp_last_pick
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_picked_tag) &&
      $stable(rsp_none_picked) && $stable(rsp_last_pick))
      else $error("stalled response changed");

   a_none_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_none_picked |-> rsp_last_pick)
      else $error("empty result not marked last");

   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_last_store |=> !req_stall)
      else $error("stall raised while loading stores");

   a_reset_ready: assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_stall)
      else $error("not ready after reset");

endmodule

bind compaction_store_picker_unit csp_checker u_csp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_last_store  (req_last_store),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_picked_tag  (rsp_picked_tag),
   .rsp_none_picked (rsp_none_picked),
   .rsp_last_pick   (rsp_last_pick)
);
`default_nettype wire
